FILE: rtl/ghc_pkg.sv
// ----------------------------------------------------------------------------
// ghc_pkg
// Shared types and constants for the binary geohash codec.
// ----------------------------------------------------------------------------
package ghc_pkg;

   localparam int COORD_W = 32;
   localparam int CODE_W  = 64;
   localparam int STEP_W  = 6;

   // Offset of a two's complement angle onto the unsigned range
   localparam logic [COORD_W-1:0] HALF_RANGE = {1'b1, {(COORD_W-1){1'b0}}};

   // Request kind carried in req_type
   typedef enum logic {
      REQ_ENCODE = 1'b0,
      REQ_DECODE = 1'b1
   } req_kind_type;

   // One input transaction
   typedef struct packed {
      req_kind_type             kind;
      logic signed [COORD_W-1:0] lat;
      logic signed [COORD_W-1:0] lon;
      logic [CODE_W-1:0]        code;
   } req_payload_type;

   // One result transaction
   typedef struct packed {
      logic [CODE_W-1:0]        code;
      logic signed [COORD_W-1:0] lat;
      logic signed [COORD_W-1:0] lon;
   } rsp_payload_type;

endpackage

FILE: rtl/ghc_csr.sv
// ----------------------------------------------------------------------------
// ghc_csr
// Step count register with write port; presents the saturated step count.
// ----------------------------------------------------------------------------
module ghc_csr #(
   parameter int MAX_STEPS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [ghc_pkg::STEP_W-1:0]  csr_data,
   output logic [ghc_pkg::STEP_W-1:0]  steps
);

   logic [ghc_pkg::STEP_W-1:0] steps_ff;
   logic [ghc_pkg::STEP_W-1:0] steps_in;

   // Writes are always taken
   assign csr_ready = 1'b1;

   always_comb begin
      steps_in = steps_ff;
      if (csr_valid) begin
         steps_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff <= ghc_pkg::STEP_W'(32);
      end else begin
         steps_ff <= steps_in;
      end
   end

   // Clamp to the largest supported step count
   assign steps = (steps_ff > ghc_pkg::STEP_W'(MAX_STEPS)) ?
                  ghc_pkg::STEP_W'(MAX_STEPS) : steps_ff;

endmodule

FILE: rtl/ghc_core.sv
// ----------------------------------------------------------------------------
// ghc_core
// Combinational encode/decode datapath: offset, shift and bit interleave.
// ----------------------------------------------------------------------------
module ghc_core (
   input  logic [ghc_pkg::STEP_W-1:0] steps,
   input  ghc_pkg::req_payload_type   req,
   output ghc_pkg::rsp_payload_type   rsp
);

   localparam int HALF_W = ghc_pkg::COORD_W;

   logic [ghc_pkg::STEP_W-1:0] shamt;
   logic [HALF_W-1:0]          lat_u;
   logic [HALF_W-1:0]          lon_u;
   logic [HALF_W-1:0]          lat_enc;
   logic [HALF_W-1:0]          lon_enc;
   logic [ghc_pkg::CODE_W-1:0] code_enc;
   logic [HALF_W-1:0]          lat_dec;
   logic [HALF_W-1:0]          lon_dec;

   // Unused low cell bits: 32 - steps, range 0..32
   assign shamt = ghc_pkg::STEP_W'(HALF_W) - steps;

   // Offset onto the unsigned range
   assign lat_u = req.lat ^ ghc_pkg::HALF_RANGE;
   assign lon_u = req.lon ^ ghc_pkg::HALF_RANGE;

   // Encode: a point on a midpoint goes low, so the cell bits are those of
   // (u - 1); the bottom of the range gives all zeros.
   always_comb begin
      lat_enc = (lat_u == '0) ? '0 : ((lat_u - HALF_W'(1)) >> shamt);
      lon_enc = (lon_u == '0) ? '0 : ((lon_u - HALF_W'(1)) >> shamt);
   end

   // Interleave, longitude bit above latitude bit
   always_comb begin
      code_enc = '0;
      for (int j = 0; j < HALF_W; j++) begin
         code_enc[2*j+1] = lon_enc[j];
         code_enc[2*j]   = lat_enc[j];
      end
   end

   // Decode: split the code, left-align the prefixes, undo the offset
   always_comb begin
      lat_dec = '0;
      lon_dec = '0;
      for (int j = 0; j < HALF_W; j++) begin
         lat_dec[j] = req.code[2*j];
         lon_dec[j] = req.code[2*j+1];
      end
      lat_dec = (lat_dec << shamt) ^ ghc_pkg::HALF_RANGE;
      lon_dec = (lon_dec << shamt) ^ ghc_pkg::HALF_RANGE;
   end

   // Result select
   always_comb begin
      rsp = '0;
      case (req.kind)
         ghc_pkg::REQ_ENCODE: begin
            rsp.code = code_enc;
         end
         ghc_pkg::REQ_DECODE: begin
            rsp.lat = lat_dec;
            rsp.lon = lon_dec;
         end
         default: begin
            rsp = '0;
         end
      endcase
   end

endmodule

FILE: rtl/geohash_codec.sv
// ----------------------------------------------------------------------------
// geohash_codec
// Binary geohash encoder/decoder with a step count register.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Payload
//  req_      in         req_valid/req_stall  req_type, req_lat_in, req_lon_in, req_code_in
//  rsp_      out        rsp_valid/rsp_stall  rsp_code_out, rsp_lat_out, rsp_lon_out
//  csr_      in         csr_valid/csr_ready  csr_data (precision_steps)
//
// One transaction per cycle while rsp_stall is low; the path runs from the input
// register through the whole datapath to the result register.
// The result register holds a valid result while rsp_stall is high; the input register
// still takes one more transaction behind it before req_stall rises.
// Reset is synchronous; it empties both stages and sets 32 steps.
// ----------------------------------------------------------------------------
module geohash_codec #(
   parameter int MAX_STEPS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_type,
   input  logic signed [ghc_pkg::COORD_W-1:0] req_lat_in,
   input  logic signed [ghc_pkg::COORD_W-1:0] req_lon_in,
   input  logic [ghc_pkg::CODE_W-1:0]         req_code_in,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [ghc_pkg::CODE_W-1:0]         rsp_code_out,
   output logic signed [ghc_pkg::COORD_W-1:0] rsp_lat_out,
   output logic signed [ghc_pkg::COORD_W-1:0] rsp_lon_out,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ghc_pkg::STEP_W-1:0]         csr_data
);

   logic [ghc_pkg::STEP_W-1:0] steps;

   logic                     s1_valid_ff;
   logic                     s1_valid_in;
   ghc_pkg::req_payload_type s1_req_ff;
   ghc_pkg::req_payload_type s1_req_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   ghc_pkg::rsp_payload_type rsp_ff;
   ghc_pkg::rsp_payload_type rsp_in;
   ghc_pkg::req_kind_type    rsp_kind_ff;
   ghc_pkg::req_kind_type    rsp_kind_in;
   ghc_pkg::rsp_payload_type core_rsp;

   logic s2_free;
   logic s1_move;
   logic req_take;

   // Step count register
   ghc_csr #(
      .MAX_STEPS (MAX_STEPS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .steps     (steps)
   );

   // Datapath
   ghc_core u_core (
      .steps (steps),
      .req   (s1_req_ff),
      .rsp   (core_rsp)
   );

   // Pipeline flow control
   assign s2_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && s2_free;
   assign req_stall = s1_valid_ff && !s2_free;
   assign req_take  = req_valid && !req_stall;

   // Next-state for both stages
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_req_in    = s1_req_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      rsp_kind_in  = rsp_kind_ff;
      if (!s1_valid_ff || s2_free) begin
         s1_valid_in = req_valid;
      end
      if (req_take) begin
         s1_req_in.kind = ghc_pkg::req_kind_type'(req_type);
         s1_req_in.lat  = req_lat_in;
         s1_req_in.lon  = req_lon_in;
         s1_req_in.code = req_code_in;
      end
      if (s2_free) begin
         rsp_valid_in = s1_valid_ff;
      end
      if (s1_move) begin
         rsp_in      = core_rsp;
         rsp_kind_in = s1_req_ff.kind;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      s1_req_ff   <= s1_req_in;
      rsp_ff      <= rsp_in;
      rsp_kind_ff <= rsp_kind_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_code_out = rsp_ff.code;
   assign rsp_lat_out  = rsp_ff.lat;
   assign rsp_lon_out  = rsp_ff.lon;

   // Checks
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && rsp_valid_ff)
      else $error("input stalled with a free pipeline stage");

   a_encode_no_coords: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind_ff == ghc_pkg::REQ_ENCODE |->
      rsp_lat_out == '0 && rsp_lon_out == '0)
      else $error("encode result carries coordinates");

   a_decode_no_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind_ff == ghc_pkg::REQ_DECODE |-> rsp_code_out == '0)
      else $error("decode result carries a code");

   a_code_width: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind_ff == ghc_pkg::REQ_ENCODE |->
      (rsp_code_out >> {steps, 1'b0}) == '0)
      else $error("code has bits above the step count");

endmodule

FILE: verif/geohash_codec_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// geohash_codec_tb
// Self-checking bench for the binary geohash encoder/decoder.
// A table of directed requests comes first. Some rows carry hand-computed
// results and the rest are scored by a behavioral bisection model. Random
// encode/decode traffic follows under several step-count settings, with
// bursty idle on the request side and stall on the result side.
// ----------------------------------------------------------------------------
module geohash_codec_tb;

   localparam int MAX_STEPS     = 32;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 180;
   localparam int DRAIN_CYCLES  = 8;
   localparam int NUM_ROWS      = 23;

   // Directed stimulus row; typed rows carry their result, others use the model
   typedef struct {
      logic [ghc_pkg::STEP_W-1:0]  steps;
      ghc_pkg::req_kind_type       kind;
      logic [ghc_pkg::COORD_W-1:0] lat;
      logic [ghc_pkg::COORD_W-1:0] lon;
      logic [ghc_pkg::CODE_W-1:0]  code;
      bit                          typed;
      logic [ghc_pkg::CODE_W-1:0]  exp_code;
      logic [ghc_pkg::COORD_W-1:0] exp_lat;
      logic [ghc_pkg::COORD_W-1:0] exp_lon;
   } vector_row_type;

   logic                               clock;
   logic                               reset;
   logic                               req_valid;
   logic                               req_stall;
   logic                               req_type;
   logic signed [ghc_pkg::COORD_W-1:0] req_lat_in;
   logic signed [ghc_pkg::COORD_W-1:0] req_lon_in;
   logic [ghc_pkg::CODE_W-1:0]         req_code_in;
   logic                               rsp_valid;
   logic                               rsp_stall;
   logic [ghc_pkg::CODE_W-1:0]         rsp_code_out;
   logic signed [ghc_pkg::COORD_W-1:0] rsp_lat_out;
   logic signed [ghc_pkg::COORD_W-1:0] rsp_lon_out;
   logic                               csr_valid;
   logic                               csr_ready;
   logic [ghc_pkg::STEP_W-1:0]         csr_data;

   ghc_pkg::rsp_payload_type    pending_results [$];
   logic [ghc_pkg::STEP_W-1:0]  cur_steps;
   bit                          idle_en;
   int                          stall_left;
   int                          error_count;
   int                          n_checked;
   int                          n_encode;
   int                          n_decode;
   int                          n_cfg;

   vector_row_type directed_rows [0:NUM_ROWS-1] = '{
      // reset setting of 32 steps: range corners, midpoints and two model-scored values
      '{6'd32, ghc_pkg::REQ_ENCODE, 32'h8000_0000, 32'h8000_0000, 64'h0, 1'b1,
        64'h0, 32'h0, 32'h0},
      '{6'd32, ghc_pkg::REQ_ENCODE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 64'h0, 1'b1,
        64'hFFFF_FFFF_FFFF_FFFC, 32'h0, 32'h0},
      '{6'd32, ghc_pkg::REQ_ENCODE, 32'h0000_0000, 32'h0000_0000, 64'h0, 1'b1,
        64'h3FFF_FFFF_FFFF_FFFF, 32'h0, 32'h0},
      '{6'd32, ghc_pkg::REQ_ENCODE, 32'h7FFF_FFFF, 32'h8000_0000, 64'h0, 1'b1,
        64'h5555_5555_5555_5554, 32'h0, 32'h0},
      '{6'd32, ghc_pkg::REQ_DECODE, 32'h0, 32'h0, 64'h0, 1'b1,
        64'h0, 32'h8000_0000, 32'h8000_0000},
      '{6'd32, ghc_pkg::REQ_DECODE, 32'h0, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
        64'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
      '{6'd32, ghc_pkg::REQ_DECODE, 32'h0, 32'h0, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1,
        64'h0, 32'h8000_0000, 32'h7FFF_FFFF},
      '{6'd32, ghc_pkg::REQ_ENCODE, 32'h1234_5678, 32'h9ABC_DEF0, 64'h0, 1'b0,
        64'h0, 32'h0, 32'h0},
      '{6'd32, ghc_pkg::REQ_DECODE, 32'h0, 32'h0, 64'h0123_4567_89AB_CDEF, 1'b0,
        64'h0, 32'h0, 32'h0},
      // zero steps: no bisection at all
      '{6'd0, ghc_pkg::REQ_ENCODE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 64'h0, 1'b1,
        64'h0, 32'h0, 32'h0},
      '{6'd0, ghc_pkg::REQ_DECODE, 32'h0, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
        64'h0, 32'h8000_0000, 32'h8000_0000},
      // one step: single bit pair, midpoint goes low
      '{6'd1, ghc_pkg::REQ_ENCODE, 32'h7FFF_FFFF, 32'h8000_0000, 64'h0, 1'b1,
        64'h1, 32'h0, 32'h0},
      '{6'd1, ghc_pkg::REQ_DECODE, 32'h0, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
        64'h0, 32'h0, 32'h0},
      '{6'd1, ghc_pkg::REQ_ENCODE, 32'h0, 32'h0, 64'h0, 1'b1,
        64'h0, 32'h0, 32'h0},
      // 16 steps: upper code bits are ignored
      '{6'd16, ghc_pkg::REQ_DECODE, 32'h0, 32'h0, 64'hFFFF_FFFF_0000_0000, 1'b1,
        64'h0, 32'h8000_0000, 32'h8000_0000},
      '{6'd16, ghc_pkg::REQ_ENCODE, 32'hC000_0001, 32'h3FFF_FFFF, 64'h0, 1'b0,
        64'h0, 32'h0, 32'h0},
      // step counts above the maximum saturate
      '{6'd63, ghc_pkg::REQ_DECODE, 32'h0, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
        64'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
      '{6'd63, ghc_pkg::REQ_ENCODE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 64'h0, 1'b1,
        64'hFFFF_FFFF_FFFF_FFFC, 32'h0, 32'h0},
      '{6'd33, ghc_pkg::REQ_ENCODE, 32'h0, 32'h0, 64'h0, 1'b1,
        64'h3FFF_FFFF_FFFF_FFFF, 32'h0, 32'h0},
      '{6'd33, ghc_pkg::REQ_DECODE, 32'h0, 32'h0, 64'h5555_5555_5555_5555, 1'b1,
        64'h0, 32'h7FFF_FFFF, 32'h8000_0000},
      // 31 and 2 steps, model scored
      '{6'd31, ghc_pkg::REQ_DECODE, 32'h0, 32'h0, 64'hDEAD_BEEF_CAFE_F00D, 1'b0,
        64'h0, 32'h0, 32'h0},
      '{6'd31, ghc_pkg::REQ_ENCODE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h0, 1'b0,
        64'h0, 32'h0, 32'h0},
      '{6'd2, ghc_pkg::REQ_ENCODE, 32'h4000_0000, 32'hC000_0000, 64'h0, 1'b0,
        64'h0, 32'h0, 32'h0}
   };

   geohash_codec #(
      .MAX_STEPS(MAX_STEPS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_type    (req_type),
      .req_lat_in  (req_lat_in),
      .req_lon_in  (req_lon_in),
      .req_code_in (req_code_in),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_code_out(rsp_code_out),
      .rsp_lat_out (rsp_lat_out),
      .rsp_lon_out (rsp_lon_out),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   // 20 ns clock
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Bisection model: encode or decode one request under a step count
   function automatic ghc_pkg::rsp_payload_type compute_geohash(
      ghc_pkg::req_kind_type kind, logic [ghc_pkg::COORD_W-1:0] lat,
      logic [ghc_pkg::COORD_W-1:0] lon, logic [ghc_pkg::CODE_W-1:0] code,
      logic [ghc_pkg::STEP_W-1:0] steps_reg);
      ghc_pkg::rsp_payload_type r;
      int unsigned     n;
      int unsigned     pos;
      logic [33:0]     lat_lo, lat_hi, lon_lo, lon_hi, lat_mid, lon_mid;
      logic [32:0]     lat_u, lon_u;
      logic            lat_b, lon_b;
      n      = (steps_reg > MAX_STEPS) ? MAX_STEPS : steps_reg;
      lat_lo = '0;
      lon_lo = '0;
      lat_hi = 34'h1_0000_0000;
      lon_hi = 34'h1_0000_0000;
      r      = '0;
      lat_u  = {1'b0, lat ^ ghc_pkg::HALF_RANGE};
      lon_u  = {1'b0, lon ^ ghc_pkg::HALF_RANGE};
      for (int i = 0; i < n; i++) begin
         lat_mid = (lat_lo + lat_hi) >> 1;
         lon_mid = (lon_lo + lon_hi) >> 1;
         if (kind == ghc_pkg::REQ_ENCODE) begin
            // strictly above the midpoint goes to the upper half
            lat_b  = ({1'b0, lat_u} > lat_mid);
            lon_b  = ({1'b0, lon_u} > lon_mid);
            r.code = {r.code[ghc_pkg::CODE_W-3:0], lon_b, lat_b};
         end else begin
            pos   = (n - i) * 2 - 1;
            lon_b = code[pos];
            lat_b = code[pos-1];
         end
         if (lat_b) lat_lo = lat_mid; else lat_hi = lat_mid;
         if (lon_b) lon_lo = lon_mid; else lon_hi = lon_mid;
      end
      if (kind == ghc_pkg::REQ_DECODE) begin
         r.lat = lat_lo[ghc_pkg::COORD_W-1:0] ^ ghc_pkg::HALF_RANGE;
         r.lon = lon_lo[ghc_pkg::COORD_W-1:0] ^ ghc_pkg::HALF_RANGE;
      end
      return r;
   endfunction

   // Random angle, weighted toward range ends and cell boundaries
   function automatic logic [ghc_pkg::COORD_W-1:0] random_angle();
      logic [ghc_pkg::COORD_W-1:0] v;
      int                          k;
      k = $urandom_range(1, 31);
      case ($urandom_range(0, 7))
         0: v = 32'h8000_0000;
         1: v = 32'h7FFF_FFFF;
         2: v = '0;
         3: v = $urandom & ~((32'd1 << k) - 32'd1);
         4: v = ($urandom & ~((32'd1 << k) - 32'd1)) | 32'd1;
         default: v = $urandom;
      endcase
      return v;
   endfunction

   function automatic logic [ghc_pkg::CODE_W-1:0] random_code();
      logic [ghc_pkg::CODE_W-1:0] v;
      case ($urandom_range(0, 9))
         0: v = '0;
         1: v = '1;
         default: v = {$urandom, $urandom};
      endcase
      return v;
   endfunction

   // Present one request and record its expected result on acceptance
   task automatic send_request(ghc_pkg::req_kind_type kind,
                               logic [ghc_pkg::COORD_W-1:0] lat,
                               logic [ghc_pkg::COORD_W-1:0] lon,
                               logic [ghc_pkg::CODE_W-1:0] code,
                               bit typed, ghc_pkg::rsp_payload_type typed_rsp);
      if (idle_en && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_type    <= kind;
      req_lat_in  <= lat;
      req_lon_in  <= lon;
      req_code_in <= code;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (typed) pending_results.push_back(typed_rsp);
      else pending_results.push_back(compute_geohash(kind, lat, lon, code, cur_steps));
      if (kind == ghc_pkg::REQ_ENCODE) n_encode++;
      else n_decode++;
   endtask

   // Hold requests, let the pipe empty, then write the step count
   task automatic write_steps(logic [ghc_pkg::STEP_W-1:0] value);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      cur_steps = value;
      n_cfg++;
   endtask

   // Result-side stall in bursts of random length, started only while idle_en is set
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Score each result transaction against the oldest expectation
   always @(posedge clock) begin : score_results
      ghc_pkg::rsp_payload_type exp_rsp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result: code %h lat %h lon %h",
                   rsp_code_out, rsp_lat_out, rsp_lon_out);
            error_count++;
         end else begin
            exp_rsp = pending_results.pop_front();
            n_checked++;
            if (rsp_code_out !== exp_rsp.code) begin
               $error("rsp_code_out: expected %h, actual %h", exp_rsp.code, rsp_code_out);
               error_count++;
            end
            if (rsp_lat_out !== exp_rsp.lat) begin
               $error("rsp_lat_out: expected %h, actual %h", exp_rsp.lat, rsp_lat_out);
               error_count++;
            end
            if (rsp_lon_out !== exp_rsp.lon) begin
               $error("rsp_lon_out: expected %h, actual %h", exp_rsp.lon, rsp_lon_out);
               error_count++;
            end
         end
      end
   end

   // Main sequence
   initial begin : main_seq
      ghc_pkg::rsp_payload_type    typed_rsp;
      logic [ghc_pkg::STEP_W-1:0]  phase_steps;
      ghc_pkg::req_kind_type       kind;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_type    = ghc_pkg::REQ_ENCODE;
      req_lat_in  = '0;
      req_lon_in  = '0;
      req_code_in = '0;
      rsp_stall   = 1'b0;
      csr_valid   = 1'b0;
      csr_data    = '0;
      stall_left  = 0;
      idle_en     = 1'b1;
      error_count = 0;
      n_checked   = 0;
      n_encode    = 0;
      n_decode    = 0;
      n_cfg       = 0;
      cur_steps   = 6'd32;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table
      for (int r = 0; r < NUM_ROWS; r++) begin
         if (directed_rows[r].steps != cur_steps) write_steps(directed_rows[r].steps);
         typed_rsp.code = directed_rows[r].exp_code;
         typed_rsp.lat  = directed_rows[r].exp_lat;
         typed_rsp.lon  = directed_rows[r].exp_lon;
         send_request(directed_rows[r].kind, directed_rows[r].lat, directed_rows[r].lon,
                      directed_rows[r].code, directed_rows[r].typed, typed_rsp);
      end

      // Random phases, each under its own step count
      typed_rsp = '0;
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            1: phase_steps = 6'd0;
            2: phase_steps = 6'd63;
            3: phase_steps = 6'd1;
            5: phase_steps = 6'd32;
            6: phase_steps = $urandom_range(33, 63);
            default: phase_steps = $urandom_range(2, 31);
         endcase
         write_steps(phase_steps);
         // quiet final phase
         if (p == PHASES - 1) idle_en = 1'b0;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // drain the pipe completely once mid-phase
            if (p == 3 && i == PHASE_ITEMS / 2) begin
               req_valid <= 1'b0;
               while (pending_results.size() != 0) @(posedge clock);
            end
            kind = $urandom_range(0, 1) ? ghc_pkg::REQ_DECODE : ghc_pkg::REQ_ENCODE;
            send_request(kind, random_angle(), random_angle(), random_code(),
                         1'b0, typed_rsp);
         end
      end

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d results: %0d encode and %0d decode transactions",
               n_checked, n_encode, n_decode);
      $display("Step count written %0d times, incl. 0, 1, 32 and saturating values", n_cfg);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
